// ===== rtl/core/amp_pkg.sv =====
// ----------------------------------------------------------------------------
// amp_pkg
// Shared constants and types of the axis move planner: field widths, register
// indexes, reset values, time-estimate coefficients and divider/root controls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amp_pkg;

  // Parameter defaults
  localparam int POSITION_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF     = 32;

  // Fixed field widths
  localparam int SPEED_W     = 16;
  localparam int ACCEL_W     = 8;
  localparam int A_W         = ACCEL_W + 1;   // accel code with zero read as 256
  localparam int PPU_W       = 10;
  localparam int MIN_TIME_W  = 16;
  localparam int PULSE_W     = 26;
  localparam int TIME_OUT_W  = 32;
  localparam int LIMIT_MIN_W = 16;
  localparam int CFG_IDX_W   = 2;

  // Shared multiplier narrow operand, divider denominator width (8*v*a)
  localparam int MUL_A_W = 16;
  localparam int DEN_W   = 28;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PPU         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIME    = 2'd3;

  // Register reset values
  localparam int UPPER_RESET    = 135;
  localparam int LOWER_RESET    = 0;
  localparam int PPU_RESET      = 80;
  localparam int MIN_TIME_RESET = 200;

  // Time estimate coefficients
  localparam int ACCEL_ZERO_VALUE = 256;
  localparam int K_ROOT           = 18750;  // t^2 = 18750 p / a
  localparam int K_ACC            = 75;     // 75 p a term
  localparam int K_CRUISE         = 4000;   // 4000 v^2 term

  // Divider / root unit controls
  typedef enum logic {
    DSQ_DIV,
    DSQ_SQRT
  } dsq_mode_t;

  typedef struct packed {
    logic      start;
    dsq_mode_t mode;
  } dsq_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dsq_sts_t;

endpackage

// ===== rtl/core/amp_cmd_if.sv =====
// ----------------------------------------------------------------------------
// amp_cmd_if
// Move command channel: valid/ready handshake with target, speed and accel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface amp_cmd_if #(
  parameter int POSITION_WIDTH = amp_pkg::POSITION_WIDTH_DEF
);
  logic                               valid;
  logic                               ready;
  logic signed [POSITION_WIDTH-1:0]   target_position;
  logic [amp_pkg::SPEED_W-1:0]        move_speed;
  logic [amp_pkg::ACCEL_W-1:0]        move_accel;

  modport source (output valid, output target_position, output move_speed,
                  output move_accel, input ready);
  modport sink   (input valid, input target_position, input move_speed,
                  input move_accel, output ready);
endinterface

// ===== rtl/core/amp_res_if.sv =====
// ----------------------------------------------------------------------------
// amp_res_if
// Move result channel: valid/ready handshake with motor command and time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface amp_res_if;
  logic                            valid;
  logic                            ready;
  logic                            direction;
  logic [amp_pkg::PULSE_W-1:0]     pulse_count;
  logic                            issue_move;
  logic [amp_pkg::SPEED_W-1:0]     motor_speed;
  logic [amp_pkg::ACCEL_W-1:0]     motor_accel;
  logic [amp_pkg::TIME_OUT_W-1:0]  move_time_ms;
  logic                            speed_error;

  modport source (output valid, output direction, output pulse_count,
                  output issue_move, output motor_speed, output motor_accel,
                  output move_time_ms, output speed_error, input ready);
  modport sink   (input valid, input direction, input pulse_count,
                  input issue_move, input motor_speed, input motor_accel,
                  input move_time_ms, input speed_error, output ready);
endinterface

// ===== rtl/core/amp_mul.sv =====
// ----------------------------------------------------------------------------
// amp_mul
// Shared registered multiplier: narrow by wide unsigned product per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amp_mul #(
  parameter int A_WIDTH = amp_pkg::MUL_A_W,
  parameter int B_WIDTH = 32
) (
  input  logic                         clk,
  input  logic [A_WIDTH-1:0]           op_a,
  input  logic [B_WIDTH-1:0]           op_b,
  output logic [A_WIDTH+B_WIDTH-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= (A_WIDTH + B_WIDTH)'(op_a) * (A_WIDTH + B_WIDTH)'(op_b);
  end

endmodule

// ===== rtl/core/amp_dsq.sv =====
// ----------------------------------------------------------------------------
// amp_dsq
// Shared shift-subtract unit: restoring division one quotient bit per cycle,
// or integer square root one result bit per cycle, on one subtractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amp_dsq #(
  parameter int NUM_W = 46
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  amp_pkg::dsq_ctl_t           ctl,
  input  logic [NUM_W-1:0]            num,
  input  logic [amp_pkg::DEN_W-1:0]   den,
  output amp_pkg::dsq_sts_t           sts,
  output logic [NUM_W-1:0]            result
);

  localparam int SQ_W  = NUM_W / 2;
  localparam int RW    = (amp_pkg::DEN_W + 1 > SQ_W + 3) ? amp_pkg::DEN_W + 1 : SQ_W + 3;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]           x_r;
  logic [NUM_W-1:0]           q_r;
  logic [RW-1:0]              rem_r;
  logic [amp_pkg::DEN_W-1:0]  den_r;
  logic [CNT_W-1:0]           cnt_r;
  amp_pkg::dsq_mode_t         mode_r;
  logic                       done_r;

  logic [RW-1:0] shifted;
  logic [RW-1:0] trial;
  logic [RW:0]   diff;
  logic          take;

  // Division brings down one dividend bit, root brings down a bit pair
  always_comb begin
    if (mode_r == amp_pkg::DSQ_DIV) begin
      shifted = {rem_r[RW-2:0], x_r[NUM_W-1]};
      trial   = RW'(den_r);
    end else begin
      shifted = {rem_r[RW-3:0], x_r[NUM_W-1:NUM_W-2]};
      trial   = RW'({q_r[SQ_W-1:0], 2'b01});
    end
    diff = {1'b0, shifted} - {1'b0, trial};
    take = ~diff[RW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
      mode_r <= amp_pkg::DSQ_DIV;
    end else if (ctl.start) begin
      x_r    <= num;
      q_r    <= '0;
      rem_r  <= '0;
      den_r  <= den;
      mode_r <= ctl.mode;
      cnt_r  <= (ctl.mode == amp_pkg::DSQ_DIV) ? CNT_W'(NUM_W) : CNT_W'(SQ_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      rem_r  <= take ? diff[RW-1:0] : shifted;
      q_r    <= {q_r[NUM_W-2:0], take};
      x_r    <= (mode_r == amp_pkg::DSQ_DIV) ? (x_r << 1) : (x_r << 2);
      cnt_r  <= cnt_r - CNT_W'(1);
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign result   = q_r;

endmodule

// ===== rtl/core/axis_move_planner.sv =====
// ----------------------------------------------------------------------------
// axis_move_planner
// Each item runs through the multiplier steps, then the one-bit-per-cycle divide/root
//   unit on NUM_W-bit numerators (NUM_W = 46 at default widths): a division on the
//   cruise path, a division then a square root on the root path; an output stall holds the item in the hand-off state.
// Items: one at a time; the next item can be taken the cycle after the
//   result is handed to the output register.
// Reset: synchronous active-low; registers return to their reset values and
//   the stored position to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_move_planner #(
  parameter int POSITION_WIDTH = amp_pkg::POSITION_WIDTH_DEF,
  parameter int TIME_WIDTH     = amp_pkg::TIME_WIDTH_DEF,
  localparam int CFG_W = (POSITION_WIDTH > amp_pkg::LIMIT_MIN_W) ?
                         POSITION_WIDTH : amp_pkg::LIMIT_MIN_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  amp_cmd_if.sink                        in_ch,
  amp_res_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [amp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);

  // --------------------------------------------------------------------------
  // Datapath widths, all derived from the position width
  // --------------------------------------------------------------------------
  localparam int PW     = POSITION_WIDTH;
  localparam int LW     = CFG_W;                  // limit registers hold 135 at any PW
  localparam int DW     = PW + 1;                 // signed difference, |d| up to 2^PW - 1
  localparam int P_W    = DW + amp_pkg::PPU_W;    // pulse count
  localparam int AP_W   = P_W + amp_pkg::A_W;     // a * p
  localparam int VV_W   = 2 * amp_pkg::SPEED_W;   // v * v
  localparam int VA_W   = amp_pkg::SPEED_W + amp_pkg::A_W;
  localparam int VV160_W = VV_W + 8;
  localparam int AP3_W  = AP_W + 2;
  localparam int CMP_W  = (VV160_W > AP3_W) ? VV160_W : AP3_W;
  localparam int N1_W   = P_W + 15;
  localparam int N2_W   = ((AP_W + 7 > VV_W + 12) ? AP_W + 7 : VV_W + 12) + 1;
  localparam int NRAW_W = (N1_W > N2_W) ? N1_W : N2_W;
  localparam int NUM_W  = ((NRAW_W + 1) / 2) * 2;  // even for bit-pair root
  localparam int MB_W   = (AP_W > VV_W) ? AP_W : VV_W;
  localparam int MP_W   = amp_pkg::MUL_A_W + MB_W;
  localparam int EXT_W  = ((NUM_W > TIME_WIDTH) ? NUM_W : TIME_WIDTH) + 1;
  localparam logic [EXT_W-1:0] TMAX_EXT = (EXT_W'(1) << TIME_WIDTH) - EXT_W'(1);

  // --------------------------------------------------------------------------
  // Sequencer states
  // --------------------------------------------------------------------------
  typedef enum logic [3:0] {
    S_IDLE,      // take a command
    S_CLAMP,     // clamp target to limits
    S_DIFF,      // difference, direction, distance; store new position
    S_MP,        // issue dist * ppu
    S_MVV,       // capture p, issue v * v
    S_MAP,       // capture v^2, issue a * p
    S_MVA,       // capture a*p, issue v * a
    S_SEL,       // capture v*a, pick root or cruise formula
    S_MK1,       // issue first numerator product
    S_MK2,       // capture it, issue 4000 v^2
    S_SUM,       // cruise numerator sum
    S_DIV_GO,    // start division
    S_DIV_WAIT,  // wait for quotient
    S_SQ_GO,     // start square root
    S_SQ_WAIT,   // wait for root
    S_FIN        // floor, saturate and hand off
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic signed [LW-1:0]            upper_r;
  logic signed [LW-1:0]            lower_r;
  logic [amp_pkg::PPU_W-1:0]       ppu_r;
  logic [amp_pkg::MIN_TIME_W-1:0]  min_time_r;

  // Axis state
  logic signed [PW-1:0]            cur_pos_r;

  // Per-item working registers
  logic signed [PW-1:0]            tgt_r;
  logic signed [PW-1:0]            clamp_r;
  logic [amp_pkg::SPEED_W-1:0]     v_r;
  logic [amp_pkg::ACCEL_W-1:0]     acode_r;
  logic [amp_pkg::A_W-1:0]         a_r;
  logic                            dir_r;
  logic                            mov_r;
  logic [DW-1:0]                   dist_r;
  logic [P_W-1:0]                  p_r;
  logic [VV_W-1:0]                 vv_r;
  logic [VV160_W-1:0]              vv160_r;
  logic [AP_W-1:0]                 ap_r;
  logic [AP3_W-1:0]                ap3_r;
  logic [VA_W-1:0]                 va_r;
  logic                            root_sel_r;
  logic [NUM_W-1:0]                num_r;
  logic [NUM_W-1:0]                t_r;

  // Output register
  logic                            out_valid_r;
  logic                            o_dir_r;
  logic [amp_pkg::PULSE_W-1:0]     o_pulse_r;
  logic                            o_move_r;
  logic [amp_pkg::SPEED_W-1:0]     o_speed_r;
  logic [amp_pkg::ACCEL_W-1:0]     o_accel_r;
  logic [amp_pkg::TIME_OUT_W-1:0]  o_time_r;
  logic                            o_err_r;

  // Shared units
  logic [amp_pkg::MUL_A_W-1:0]     mul_a;
  logic [MB_W-1:0]                 mul_b;
  logic [MP_W-1:0]                 mul_prod;
  amp_pkg::dsq_ctl_t               dsq_ctl;
  amp_pkg::dsq_sts_t               dsq_sts;
  logic [NUM_W-1:0]                dsq_num;
  logic [amp_pkg::DEN_W-1:0]       dsq_den;
  logic [NUM_W-1:0]                dsq_q;

  // Combinational helpers
  logic                            in_fire;
  logic                            out_free;
  logic signed [LW-1:0]            tgt_ext;
  logic signed [LW-1:0]            clip_hi;
  logic signed [LW-1:0]            clip_lo;
  logic signed [DW-1:0]            diff_w;
  logic [VV_W-1:0]                 vv_w;
  logic [AP_W-1:0]                 ap_w;
  logic [EXT_W-1:0]                t_ext;
  logic [EXT_W-1:0]                min_ext;
  logic [EXT_W-1:0]                raised;
  logic [EXT_W-1:0]                time_fin;

  // Hold ready low while reset is applied so no item is taken then
  assign in_ch.ready = rst_n & (state_r == S_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign out_free    = ~out_valid_r | out_ch.ready;

  // Clamp to the upper limit first, then the lower one, so a crossed pair
  // leaves the lower limit in charge
  assign tgt_ext = LW'(tgt_r);
  assign clip_hi = (tgt_ext > upper_r) ? upper_r : tgt_ext;
  assign clip_lo = (clip_hi < lower_r) ? lower_r : clip_hi;

  assign diff_w  = DW'(clamp_r) - DW'(cur_pos_r);
  assign vv_w    = VV_W'(mul_prod);
  assign ap_w    = AP_W'(mul_prod);

  // Raise to the floor, saturate; zero speed forces the saturated time
  assign t_ext    = EXT_W'(t_r);
  assign min_ext  = EXT_W'(min_time_r);
  assign raised   = (t_ext < min_ext) ? min_ext : t_ext;
  assign time_fin = (v_r == '0)        ? TMAX_EXT :
                    (raised > TMAX_EXT) ? TMAX_EXT : raised;

  // --------------------------------------------------------------------------
  // Shared multiplier operands, one product per sequencer step
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MP: begin
        mul_a = amp_pkg::MUL_A_W'(ppu_r);
        mul_b = MB_W'(dist_r);
      end
      S_MVV: begin
        mul_a = v_r;
        mul_b = MB_W'(v_r);
      end
      S_MAP: begin
        mul_a = amp_pkg::MUL_A_W'(a_r);
        mul_b = MB_W'(p_r);
      end
      S_MVA: begin
        mul_a = v_r;
        mul_b = MB_W'(a_r);
      end
      S_MK1: begin
        if (root_sel_r) begin
          mul_a = amp_pkg::MUL_A_W'(amp_pkg::K_ROOT);
          mul_b = MB_W'(p_r);
        end else begin
          mul_a = amp_pkg::MUL_A_W'(amp_pkg::K_ACC);
          mul_b = MB_W'(ap_r);
        end
      end
      S_MK2: begin
        mul_a = amp_pkg::MUL_A_W'(amp_pkg::K_CRUISE);
        mul_b = MB_W'(vv_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider feeds: 18750p / a on the root path, num / 8va on the cruise path;
  // the root takes the quotient still held in the unit
  always_comb begin
    dsq_ctl.start = (state_r == S_DIV_GO) || (state_r == S_SQ_GO);
    dsq_ctl.mode  = (state_r == S_SQ_GO) ? amp_pkg::DSQ_SQRT : amp_pkg::DSQ_DIV;
    dsq_num       = (state_r == S_SQ_GO) ? dsq_q : num_r;
    dsq_den       = root_sel_r ? amp_pkg::DEN_W'(a_r) : amp_pkg::DEN_W'({va_r, 3'b000});
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_fire) state_nxt = S_CLAMP;
      S_CLAMP:    state_nxt = S_DIFF;
      S_DIFF:     state_nxt = S_MP;
      S_MP:       state_nxt = S_MVV;
      S_MVV:      state_nxt = S_MAP;
      S_MAP:      state_nxt = S_MVA;
      S_MVA:      state_nxt = S_SEL;
      S_SEL:      state_nxt = S_MK1;
      S_MK1:      state_nxt = S_MK2;
      S_MK2:      state_nxt = root_sel_r ? S_DIV_GO : S_SUM;
      S_SUM:      state_nxt = S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (dsq_sts.done) state_nxt = root_sel_r ? S_SQ_GO : S_FIN;
      S_SQ_GO:    state_nxt = S_SQ_WAIT;
      S_SQ_WAIT:  if (dsq_sts.done) state_nxt = S_FIN;
      S_FIN:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // State, configuration, working and output registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      upper_r     <= LW'(amp_pkg::UPPER_RESET);
      lower_r     <= LW'(amp_pkg::LOWER_RESET);
      ppu_r       <= amp_pkg::PPU_W'(amp_pkg::PPU_RESET);
      min_time_r  <= amp_pkg::MIN_TIME_W'(amp_pkg::MIN_TIME_RESET);
      cur_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes; limits are sign-extended from the position width
      if (cfg_we) begin
        case (cfg_index)
          amp_pkg::CFG_UPPER_LIMIT: upper_r    <= LW'($signed(cfg_data[PW-1:0]));
          amp_pkg::CFG_LOWER_LIMIT: lower_r    <= LW'($signed(cfg_data[PW-1:0]));
          amp_pkg::CFG_PPU:         ppu_r      <= cfg_data[amp_pkg::PPU_W-1:0];
          amp_pkg::CFG_MIN_TIME:    min_time_r <= cfg_data[amp_pkg::MIN_TIME_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once the sink takes it; the hand-off state reloads it
      if (out_valid_r && out_ch.ready && (state_r != S_FIN)) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            tgt_r   <= in_ch.target_position;
            v_r     <= in_ch.move_speed;
            acode_r <= in_ch.move_accel;
          end
        end
        S_CLAMP: begin
          clamp_r <= PW'(clip_lo);
          a_r     <= (acode_r == '0) ? amp_pkg::A_W'(amp_pkg::ACCEL_ZERO_VALUE)
                                     : amp_pkg::A_W'(acode_r);
        end
        S_DIFF: begin
          // Direction is 1 for a negative or zero move
          dir_r     <= diff_w[DW-1] | (diff_w == '0);
          mov_r     <= (diff_w != '0);
          dist_r    <= diff_w[DW-1] ? $unsigned(-diff_w) : $unsigned(diff_w);
          cur_pos_r <= clamp_r;
        end
        S_MVV: p_r <= P_W'(mul_prod);
        S_MAP: begin
          vv_r    <= vv_w;
          vv160_r <= (VV160_W'(vv_w) << 7) + (VV160_W'(vv_w) << 5);
        end
        S_MVA: begin
          ap_r  <= ap_w;
          ap3_r <= (AP3_W'(ap_w) << 1) + AP3_W'(ap_w);
        end
        S_SEL: begin
          va_r       <= VA_W'(mul_prod);
          // Speed high enough that the move never reaches cruise: root formula
          root_sel_r <= (CMP_W'(vv160_r) >= CMP_W'(ap3_r));
        end
        S_MK2: num_r <= NUM_W'(mul_prod);
        S_SUM: num_r <= num_r + NUM_W'(mul_prod);
        S_DIV_WAIT: if (dsq_sts.done && !root_sel_r) t_r <= dsq_q;
        S_SQ_WAIT:  if (dsq_sts.done) t_r <= dsq_q;
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_dir_r     <= dir_r;
            o_pulse_r   <= amp_pkg::PULSE_W'(p_r);
            o_move_r    <= mov_r;
            o_speed_r   <= v_r;
            o_accel_r   <= acode_r;
            o_time_r    <= amp_pkg::TIME_OUT_W'(time_fin);
            o_err_r     <= (v_r == '0);
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Shared units
  // --------------------------------------------------------------------------
  amp_mul #(
    .A_WIDTH (amp_pkg::MUL_A_W),
    .B_WIDTH (MB_W)
  ) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_prod)
  );

  amp_dsq #(
    .NUM_W (NUM_W)
  ) u_dsq (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (dsq_ctl),
    .num    (dsq_num),
    .den    (dsq_den),
    .sts    (dsq_sts),
    .result (dsq_q)
  );

  // --------------------------------------------------------------------------
  // Result channel
  // --------------------------------------------------------------------------
  assign out_ch.valid        = out_valid_r;
  assign out_ch.direction    = o_dir_r;
  assign out_ch.pulse_count  = o_pulse_r;
  assign out_ch.issue_move   = o_move_r;
  assign out_ch.motor_speed  = o_speed_r;
  assign out_ch.motor_accel  = o_accel_r;
  assign out_ch.move_time_ms = o_time_r;
  assign out_ch.speed_error  = o_err_r;

endmodule
